>>> src/integer_printf_formatter_macros.svh
// ----------------------------------------------------------------------------
// Integer printf formatter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PRINTF_FORMATTER_MACROS_SVH
`define INTEGER_PRINTF_FORMATTER_MACROS_SVH

// Same-cycle implication.
`define IPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ipf_pkg.sv
// ----------------------------------------------------------------------------
// Integer printf formatter package
// Shared types, codes, ASCII constants and the digit-to-character helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipf_pkg;

  // Longest text emitted for one request.
  localparam int MAX_FIELD  = 64;
  localparam int LEN_W      = $clog2(MAX_FIELD + 2);
  // Digit slots: 22 octal digits cover 64 bits.
  localparam int NUM_DIGITS = 22;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  // Conversion codes
  localparam logic [2:0] ACT_DEC  = 3'd0;
  localparam logic [2:0] ACT_UNS  = 3'd1;
  localparam logic [2:0] ACT_OCT  = 3'd2;
  localparam logic [2:0] ACT_HEX  = 3'd3;
  localparam logic [2:0] ACT_HEXU = 3'd4;

  // Size codes
  localparam logic [1:0] SZ_INT   = 2'd0;
  localparam logic [1:0] SZ_SHORT = 2'd1;
  localparam logic [1:0] SZ_LONG  = 2'd2;

  // ASCII
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_A_UP  = 8'd65;
  localparam logic [7:0] CH_X_UP  = 8'd88;
  localparam logic [7:0] CH_A_LO  = 8'd97;
  localparam logic [7:0] CH_X_LO  = 8'd120;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         action;
    logic [1:0]         size_mode;
    logic               left_justify;
    logic               force_sign;
    logic               space_sign;
    logic               alt_form;
    logic               zero_pad;
    logic [6:0]         field_width;
    logic [5:0]         digit_precision;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
    logic       empty_text;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic scan;
    logic layout;
    logic emit;
  } ipf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic at_last;
  } ipf_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else begin
      return (upper ? CH_A_UP : CH_A_LO) + d8 - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/ipf_ctrl.sv
// ----------------------------------------------------------------------------
// Integer printf formatter controller
// Sequences load, binary-to-decimal conversion, scan, layout and emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipf_ctrl
  import ipf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire ipf_status_t status,
  output ipf_cmd_t         cmd,
  output logic             in_stall
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_LAYOUT,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load     = in_valid && !in_stall_r;
        in_stall_nxt = cmd.load;
        if (cmd.load) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = !status.conv_done;
        if (status.conv_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_LAYOUT;
      end
      ST_LAYOUT: begin
        cmd.layout = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.at_last) begin
          state_nxt    = ST_IDLE;
          in_stall_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

`default_nettype wire

>>> src/ipf_datapath.sv
// ----------------------------------------------------------------------------
// Integer printf formatter datapath
// Holds the request, digit register, text layout and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_printf_formatter_macros.svh"

module ipf_datapath
  import ipf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ipf_cmd_t  cmd,
  input  wire in_item_t  in_item,
  input  wire logic      out_stall,
  output ipf_status_t    status,
  output logic           out_valid,
  output out_item_t      out_item
);

  // Request flags
  logic signed_r, neg_r, plus_r, space_r, alt_r, zero_r, left_r, upper_r;
  logic oct_r, hex_r;
  logic [LEN_W-1:0] width_r;
  logic [5:0]       prec_r;

  // Conversion
  logic [63:0]                      mag_r, mag_nxt;
  logic [LEN_W-1:0]                 conv_left_r, conv_left_nxt;
  logic [NUM_DIGITS-1:0][3:0]       digits_r, digits_nxt;
  logic [NUM_DIGITS-1:0][3:0]       adj;
  logic [DIG_CNT_W-1:0]             n_r, n_scan;

  // Layout
  logic [LEN_W-1:0] lead_r, pre_end_r, zero_end_r, dig_end_r, last_pos_r;
  logic             empty_r;
  logic [LEN_W-1:0] n_ext, prec_ext, dc0, dc, body, total, fill, zp, sp, lead;
  logic [LEN_W-1:0] pre_end, zero_end, dig_end, cnt;
  logic [1:0]       pl;

  // Emission
  logic [LEN_W-1:0] pos_r;
  logic [LEN_W-1:0] dig_off;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  // Load-time value shaping
  logic [63:0] raw, ext, mag_ld, pre_ld;
  logic [65:0] mag66;
  logic        ld_signed, ld_neg, ld_oct, ld_hex;
  logic [LEN_W-1:0] ld_steps;
  logic [NUM_DIGITS-1:0][3:0] ld_digits;

  always_comb begin
    raw       = in_item.value;
    ld_signed = (in_item.action == ACT_DEC);
    ld_oct    = (in_item.action == ACT_OCT);
    ld_hex    = (in_item.action == ACT_HEX) || (in_item.action == ACT_HEXU);
    case (in_item.size_mode)
      SZ_SHORT: begin
        ext      = ld_signed ? {{48{raw[15]}}, raw[15:0]} : {48'b0, raw[15:0]};
        ld_steps = LEN_W'(16);
      end
      SZ_INT: begin
        ext      = ld_signed ? {{32{raw[31]}}, raw[31:0]} : {32'b0, raw[31:0]};
        ld_steps = LEN_W'(32);
      end
      default: begin
        ext      = raw;
        ld_steps = LEN_W'(64);
      end
    endcase
    ld_neg = ld_signed && ext[63];
    mag_ld = ld_neg ? (~ext + 64'd1) : ext;
    // Align the top bit of the sized magnitude to bit 63 for the shifter.
    case (in_item.size_mode)
      SZ_SHORT: pre_ld = mag_ld << 48;
      SZ_INT:   pre_ld = mag_ld << 32;
      default:  pre_ld = mag_ld;
    endcase
    mag66     = {2'b00, mag_ld};
    ld_digits = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (ld_oct) begin
        ld_digits[i] = {1'b0, mag66[3*i +: 3]};
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ld_hex) begin
        ld_digits[i] = mag66[4*i +: 4];
      end
    end
  end

  // Shift-and-add-3 step: one magnitude bit per cycle into the BCD digits.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (digits_r[i] >= 4'd5) ? (digits_r[i] + 4'd3) : digits_r[i];
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    conv_left_nxt = conv_left_r;
    digits_nxt    = digits_r;
    if (cmd.load) begin
      mag_nxt       = pre_ld;
      conv_left_nxt = (ld_oct || ld_hex) ? '0 : ld_steps;
      digits_nxt    = ld_digits;
    end else if (cmd.conv_step) begin
      mag_nxt       = {mag_r[62:0], 1'b0};
      conv_left_nxt = conv_left_r - LEN_W'(1);
      digits_nxt    = {adj[NUM_DIGITS-1][2:0], adj[NUM_DIGITS-2:0], mag_r[63]};
    end
  end

  // Count significant digits.
  always_comb begin
    n_scan = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits_r[i] != 4'd0) begin
        n_scan = DIG_CNT_W'(i + 1);
      end
    end
  end

  // Text layout: [spaces] prefix zeros digits [spaces]
  always_comb begin
    n_ext    = LEN_W'(n_r);
    prec_ext = LEN_W'(prec_r);
    dc0      = (n_ext > prec_ext) ? n_ext : prec_ext;
    dc       = (oct_r && alt_r && (dc0 == n_ext)) ? n_ext + LEN_W'(1) : dc0;
    if (signed_r) begin
      pl = (neg_r || plus_r || space_r) ? 2'd1 : 2'd0;
    end else begin
      pl = (hex_r && alt_r && (n_r != '0)) ? 2'd2 : 2'd0;
    end
    body     = dc + LEN_W'(pl);
    total    = (width_r > body) ? width_r : body;
    fill     = total - body;
    zp       = zero_r ? fill : '0;
    sp       = zero_r ? '0 : fill;
    lead     = left_r ? '0 : sp;
    pre_end  = lead + LEN_W'(pl);
    zero_end = pre_end + zp + (dc - n_ext);
    dig_end  = zero_end + n_ext;
    cnt      = (total > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : total;
  end

  // Character at the current position.
  always_comb begin
    dig_off          = dig_end_r - LEN_W'(1) - pos_r;
    out_nxt.empty_text = empty_r;
    out_nxt.last_char  = empty_r || (pos_r == last_pos_r);
    if (empty_r) begin
      out_nxt.out_char = CH_NUL;
    end else if (pos_r < lead_r) begin
      out_nxt.out_char = CH_SPACE;
    end else if (pos_r < pre_end_r) begin
      if (pos_r != lead_r) begin
        out_nxt.out_char = upper_r ? CH_X_UP : CH_X_LO;
      end else if (!signed_r) begin
        out_nxt.out_char = CH_ZERO;
      end else if (neg_r) begin
        out_nxt.out_char = CH_MINUS;
      end else if (plus_r) begin
        out_nxt.out_char = CH_PLUS;
      end else begin
        out_nxt.out_char = CH_SPACE;
      end
    end else if (pos_r < zero_end_r) begin
      out_nxt.out_char = CH_ZERO;
    end else if (pos_r < dig_end_r) begin
      out_nxt.out_char = digit_char(digits_r[dig_off[DIG_IDX_W-1:0]], upper_r);
    end else begin
      out_nxt.out_char = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    digits_r <= digits_nxt;
    if (cmd.load) begin
      signed_r <= (in_item.action == ACT_DEC);
      neg_r    <= ld_neg;
      plus_r   <= in_item.force_sign;
      space_r  <= in_item.space_sign;
      alt_r    <= in_item.alt_form;
      zero_r   <= in_item.zero_pad && !in_item.left_justify;
      left_r   <= in_item.left_justify;
      upper_r  <= (in_item.action == ACT_HEXU);
      oct_r    <= ld_oct;
      hex_r    <= ld_hex;
      width_r  <= (in_item.field_width > 7'(MAX_FIELD)) ? LEN_W'(MAX_FIELD)
                                                         : LEN_W'(in_item.field_width);
      prec_r   <= in_item.digit_precision;
      pos_r    <= '0;
    end
    if (cmd.scan) begin
      n_r <= n_scan;
    end
    if (cmd.layout) begin
      lead_r     <= lead;
      pre_end_r  <= pre_end;
      zero_end_r <= zero_end;
      dig_end_r  <= dig_end;
      last_pos_r <= cnt - LEN_W'(1);
      empty_r    <= (cnt == '0);
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
      pos_r <= pos_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      conv_left_r <= conv_left_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.conv_done = (conv_left_r == '0);
  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.at_last   = empty_r || (pos_r == last_pos_r);
  assign out_valid        = out_valid_r;
  assign out_item         = out_r;

  `IPF_ASSERT_IMP(a_conv_in_count, cmd.conv_step, conv_left_r != '0, "conversion step past its count")
  `IPF_ASSERT_IMP(a_emit_in_text, cmd.emit, empty_r || (pos_r <= last_pos_r), "emit past end of text")
  `IPF_ASSERT_NXT(a_layout_order, cmd.layout, (lead_r <= pre_end_r) && (pre_end_r <= zero_end_r) && (zero_end_r <= dig_end_r), "text segments out of order")

endmodule

`default_nettype wire

>>> src/integer_printf_formatter.sv
// ----------------------------------------------------------------------------
// Integer printf formatter
// Formats one integer as printf text (d, u, o, x, X), one character a transfer.
// ----------------------------------------------------------------------------
// From an accepted request: load, conversion (d, u only), scan, layout, emit.
// Throughput: one character per cycle after that while out_stall is low, up
//   to 64 per request; the next request is taken the cycle after the final
//   character is registered. The one-bit-per-cycle shift-and-add-3 decimal
//   converter sets the wait before the first character for d and u.
// Reset: synchronous, active low; clears controller and output valid, input
//   stalled in reset and released once the controller is idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_printf_formatter
  import ipf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // Request channel
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  // Character channel
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  ipf_cmd_t    cmd;
  ipf_status_t status;

  // Controller: walks load, convert, scan, layout and emit phases.
  ipf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Datapath: digits, layout positions and the output register that
  // holds a transfer while the receiver stalls.
  ipf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
